FILE: rtl/core/rwhp_pkg.sv
// Shared constants for the RIFF/WAVE header parser: field widths,
// status codes and the little-endian chunk identifiers. No dependencies.
`timescale 1ns / 1ps

package rwhp_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam int HALF_W = 16;
    localparam int STATUS_W = 3;
    localparam int OUT_DATA_W = 168;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HEADER  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SAMPLE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SKIPPED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_RIFF = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_WAVE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_FMT  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd6;

    // Identifiers as they read after four bytes shifted in little-endian
    localparam logic [WORD_W-1:0] ID_RIFF = 32'h4646_4952;
    localparam logic [WORD_W-1:0] ID_WAVE = 32'h4556_4157;
    localparam logic [WORD_W-1:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [WORD_W-1:0] ID_DATA = 32'h6174_6164;

    // Size of the fixed part of the fmt body
    localparam logic [WORD_W-1:0] FMT_BODY_BYTES = 32'd16;

endpackage

FILE: rtl/core/riff_wave_header_parser.sv
// RIFF/WAVE header parser top level: byte-stream parser and result register.
// Depends on rwhp_pkg for widths, status codes and identifiers.
`timescale 1ns / 1ps

// Takes a WAV file one byte per transaction (s_tuser marks the first byte
// of a file) and returns one result per byte: a status code on m_tuser,
// the data byte and last-byte mark while inside the data chunk, and the
// captured format fields. One byte is accepted every cycle while s_tready is high;
// each result is loaded into the output register in the cycle after its byte, and
// s_tready drops only while that register holds a result that m_tready
// has not taken. RIFF, WAVE and fmt identifiers are checked on their fourth
// byte; after an error or the end of the data chunk bytes are reported as
// ignored until the next start mark. Non-data chunks and fmt bytes past 16
// are skipped by their size; no pad byte is skipped for odd sizes.
module riff_wave_header_parser
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    input  logic [0:0]   s_tuser,   // [0] start_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // [7:0] sample_byte, [23:8] format_tag,
                                    // [39:24] channel_count, [71:40] sample_rate,
                                    // [103:72] byte_rate, [119:104] block_align,
                                    // [135:120] bits_per_sample,
                                    // [167:136] data_bytes_left
    output logic [2:0]   m_tuser,   // [2:0] status
    output logic         m_tlast    // last_sample
);

    localparam logic [3:0] PH_RIFF_ID    = 4'd0;
    localparam logic [3:0] PH_RIFF_SIZE  = 4'd1;
    localparam logic [3:0] PH_WAVE_ID    = 4'd2;
    localparam logic [3:0] PH_FMT_ID     = 4'd3;
    localparam logic [3:0] PH_FMT_SIZE   = 4'd4;
    localparam logic [3:0] PH_FMT_BODY   = 4'd5;
    localparam logic [3:0] PH_FMT_EXTRA  = 4'd6;
    localparam logic [3:0] PH_CHUNK_ID   = 4'd7;
    localparam logic [3:0] PH_CHUNK_SIZE = 4'd8;
    localparam logic [3:0] PH_SKIP       = 4'd9;
    localparam logic [3:0] PH_DATA       = 4'd10;
    localparam logic [3:0] PH_DONE       = 4'd11;

    localparam logic [4:0] IDX_WORD_END = 5'd4;
    localparam logic [4:0] IDX_BODY_END = 5'd16;
    localparam logic [4:0] IDX_TAG      = 5'd1;
    localparam logic [4:0] IDX_CHANNELS = 5'd3;
    localparam logic [4:0] IDX_RATE     = 5'd7;
    localparam logic [4:0] IDX_BYTERATE = 5'd11;
    localparam logic [4:0] IDX_ALIGN    = 5'd13;
    localparam logic [4:0] IDX_BITS     = 5'd15;

    // Parser state
    logic [3:0]                   phase_reg, phase_next;
    logic [4:0]                   idx_reg, idx_next;
    logic [rwhp_pkg::WORD_W-1:0]  word_reg, word_next;
    logic [rwhp_pkg::WORD_W-1:0]  remain_reg, remain_next;
    logic                         is_data_reg, is_data_next;
    logic [rwhp_pkg::HALF_W-1:0]  tag_reg, tag_next;
    logic [rwhp_pkg::HALF_W-1:0]  channels_reg, channels_next;
    logic [rwhp_pkg::WORD_W-1:0]  rate_reg, rate_next;
    logic [rwhp_pkg::WORD_W-1:0]  byterate_reg, byterate_next;
    logic [rwhp_pkg::HALF_W-1:0]  align_reg, align_next;
    logic [rwhp_pkg::HALF_W-1:0]  bits_reg, bits_next;

    // Result register
    logic                             out_valid_reg;
    logic [rwhp_pkg::STATUS_W-1:0]    out_user_reg, status_next;
    logic                             out_last_reg, last_next;
    logic [rwhp_pkg::OUT_DATA_W-1:0]  out_data_reg, data_next;

    // State as seen by this byte: a start mark clears everything first
    logic                             start;
    logic [3:0]                       cur_phase;
    logic [4:0]                       cur_idx;
    logic [rwhp_pkg::WORD_W-1:0]      cur_word;
    logic [rwhp_pkg::WORD_W-1:0]      cur_remain;
    logic                             cur_is_data;
    logic [rwhp_pkg::WORD_W-1:0]      word_shift;
    logic [4:0]                       idx_inc;
    logic                             word_done;
    logic [rwhp_pkg::WORD_W-1:0]      remain_dec;
    logic [rwhp_pkg::BYTE_W-1:0]      sample_next;
    logic [rwhp_pkg::WORD_W-1:0]      left_next;
    logic                             accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign start       = s_tuser[0];
    assign cur_phase   = start ? PH_RIFF_ID : phase_reg;
    assign cur_idx     = start ? 5'd0 : idx_reg;
    assign cur_word    = start ? '0 : word_reg;
    assign cur_remain  = start ? '0 : remain_reg;
    assign cur_is_data = start ? 1'b0 : is_data_reg;

    assign word_shift = {s_tdata, cur_word[rwhp_pkg::WORD_W-1:rwhp_pkg::BYTE_W]};
    assign idx_inc    = cur_idx + 5'd1;
    assign word_done  = idx_inc >= IDX_WORD_END;
    assign remain_dec = cur_remain - rwhp_pkg::WORD_W'(1);

    always_comb
    begin
        phase_next    = cur_phase;
        idx_next      = cur_idx;
        word_next     = cur_word;
        remain_next   = cur_remain;
        is_data_next  = cur_is_data;
        tag_next      = start ? '0 : tag_reg;
        channels_next = start ? '0 : channels_reg;
        rate_next     = start ? '0 : rate_reg;
        byterate_next = start ? '0 : byterate_reg;
        align_next    = start ? '0 : align_reg;
        bits_next     = start ? '0 : bits_reg;
        status_next   = rwhp_pkg::ST_HEADER;
        sample_next   = '0;
        last_next     = 1'b0;
        left_next     = '0;

        case (cur_phase)
            PH_RIFF_ID, PH_RIFF_SIZE, PH_WAVE_ID, PH_FMT_ID, PH_FMT_SIZE,
            PH_CHUNK_ID, PH_CHUNK_SIZE:
            begin
                word_next = word_shift;
                idx_next  = word_done ? 5'd0 : idx_inc;
                if (word_done)
                begin
                    case (cur_phase)
                        PH_RIFF_ID:
                        begin
                            if (word_shift != rwhp_pkg::ID_RIFF)
                            begin
                                status_next = rwhp_pkg::ST_BAD_RIFF;
                                phase_next  = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_RIFF_SIZE;
                            end
                        end
                        PH_RIFF_SIZE:
                        begin
                            phase_next = PH_WAVE_ID;
                        end
                        PH_WAVE_ID:
                        begin
                            if (word_shift != rwhp_pkg::ID_WAVE)
                            begin
                                status_next = rwhp_pkg::ST_BAD_WAVE;
                                phase_next  = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_FMT_ID;
                            end
                        end
                        PH_FMT_ID:
                        begin
                            if (word_shift != rwhp_pkg::ID_FMT)
                            begin
                                status_next = rwhp_pkg::ST_BAD_FMT;
                                phase_next  = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_FMT_SIZE;
                            end
                        end
                        PH_FMT_SIZE:
                        begin
                            // keep only the bytes past the fixed 16-byte body
                            remain_next = (word_shift > rwhp_pkg::FMT_BODY_BYTES) ?
                                word_shift - rwhp_pkg::FMT_BODY_BYTES : '0;
                            phase_next  = PH_FMT_BODY;
                        end
                        PH_CHUNK_ID:
                        begin
                            is_data_next = (word_shift == rwhp_pkg::ID_DATA);
                            phase_next   = PH_CHUNK_SIZE;
                        end
                        default:
                        begin
                            remain_next = word_shift;
                            if (cur_is_data)
                            begin
                                phase_next = (word_shift != '0) ? PH_DATA : PH_DONE;
                            end
                            else
                            begin
                                phase_next = (word_shift != '0) ? PH_SKIP : PH_CHUNK_ID;
                            end
                        end
                    endcase
                end
            end
            PH_FMT_BODY:
            begin
                word_next = word_shift;
                case (cur_idx)
                    IDX_TAG:      tag_next      = word_shift[31:16];
                    IDX_CHANNELS: channels_next = word_shift[31:16];
                    IDX_RATE:     rate_next     = word_shift;
                    IDX_BYTERATE: byterate_next = word_shift;
                    IDX_ALIGN:    align_next    = word_shift[31:16];
                    IDX_BITS:     bits_next     = word_shift[31:16];
                    default:      ;
                endcase
                if (idx_inc >= IDX_BODY_END)
                begin
                    idx_next   = 5'd0;
                    phase_next = (cur_remain != '0) ? PH_FMT_EXTRA : PH_CHUNK_ID;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            PH_FMT_EXTRA, PH_SKIP:
            begin
                status_next = rwhp_pkg::ST_SKIPPED;
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    phase_next = PH_CHUNK_ID;
                end
            end
            PH_DATA:
            begin
                status_next = rwhp_pkg::ST_SAMPLE;
                sample_next = s_tdata;
                remain_next = remain_dec;
                left_next   = remain_dec;
                if (remain_dec == '0)
                begin
                    last_next  = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                status_next = rwhp_pkg::ST_IGNORED;
                phase_next  = PH_DONE;
            end
        endcase

        data_next = {left_next, bits_next, align_next, byterate_next, rate_next,
                     channels_next, tag_next, sample_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RIFF_ID;
            idx_reg       <= '0;
            word_reg      <= '0;
            remain_reg    <= '0;
            is_data_reg   <= 1'b0;
            tag_reg       <= '0;
            channels_reg  <= '0;
            rate_reg      <= '0;
            byterate_reg  <= '0;
            align_reg     <= '0;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                idx_reg      <= idx_next;
                word_reg     <= word_next;
                remain_reg   <= remain_next;
                is_data_reg  <= is_data_next;
                tag_reg      <= tag_next;
                channels_reg <= channels_next;
                rate_reg     <= rate_next;
                byterate_reg <= byterate_next;
                align_reg    <= align_next;
                bits_reg     <= bits_next;
            end
            // hold the result until taken; refill in the same cycle
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_user_reg <= status_next;
            out_last_reg <= last_next;
            out_data_reg <= data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: dv/riff_wave_header_parser_test.sv
// Self-checking testbench for riff_wave_header_parser: streams WAV files byte
// by byte and checks every result against a built-in parse tracker.
// Depends on rwhp_pkg and the riff_wave_header_parser RTL.
`timescale 1ns / 1ps

module riff_wave_header_parser_test;

    typedef enum logic [3:0] {
        PH_RIFF_ID, PH_RIFF_SIZE, PH_WAVE_ID, PH_FMT_ID, PH_FMT_SIZE, PH_FMT_BODY,
        PH_FMT_EXTRA, PH_CHUNK_ID, PH_CHUNK_SIZE, PH_SKIP, PH_DATA, PH_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  sample;
        logic        last;
        logic [15:0] tag;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [15:0] align;
        logic [15:0] bits;
        logic [31:0] left;
    } wav_result_t;

    class wav_parse_tracker;
        wav_result_t  pending_results[$];
        parse_phase_t phase;
        logic [4:0]   idx;
        logic [31:0]  word;
        logic [31:0]  remaining;
        logic [31:0]  chunk_id;
        logic [15:0]  tag;
        logic [15:0]  chans;
        logic [31:0]  rate;
        logic [31:0]  brate;
        logic [15:0]  align;
        logic [15:0]  bits;
        int errors;
        int checked;
        int samples;
        int lasts;
        int bad_ids;
        int skipped;

        function new();
            restart();
            errors = 0;
            checked = 0;
            samples = 0;
            lasts = 0;
            bad_ids = 0;
            skipped = 0;
        endfunction

        function void restart();
            phase = PH_RIFF_ID;
            idx = '0;
            word = '0;
            remaining = '0;
            chunk_id = '0;
            tag = '0;
            chans = '0;
            rate = '0;
            brate = '0;
            align = '0;
            bits = '0;
        endfunction

        // Shift one byte into the little-endian word; true once four are in
        function bit shift_in(logic [7:0] b);
            word = {b, word[31:8]};
            idx = idx + 5'd1;
            if (idx >= 5'd4)
            begin
                idx = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Note an accepted byte and queue the result it must produce
        function logic [2:0] predict_byte(logic [7:0] b, logic sof);
            wav_result_t r;
            r = '0;
            r.status = rwhp_pkg::ST_HEADER;
            if (sof)
                restart();
            case (phase)
                PH_RIFF_ID:
                    if (shift_in(b))
                    begin
                        chunk_id = word;
                        if (word != rwhp_pkg::ID_RIFF)
                        begin
                            r.status = rwhp_pkg::ST_BAD_RIFF;
                            phase = PH_DONE;
                        end
                        else
                            phase = PH_RIFF_SIZE;
                    end
                PH_RIFF_SIZE:
                    if (shift_in(b))
                        phase = PH_WAVE_ID;
                PH_WAVE_ID:
                    if (shift_in(b))
                    begin
                        if (word != rwhp_pkg::ID_WAVE)
                        begin
                            r.status = rwhp_pkg::ST_BAD_WAVE;
                            phase = PH_DONE;
                        end
                        else
                            phase = PH_FMT_ID;
                    end
                PH_FMT_ID:
                    if (shift_in(b))
                    begin
                        chunk_id = word;
                        if (word != rwhp_pkg::ID_FMT)
                        begin
                            r.status = rwhp_pkg::ST_BAD_FMT;
                            phase = PH_DONE;
                        end
                        else
                            phase = PH_FMT_SIZE;
                    end
                PH_FMT_SIZE:
                    if (shift_in(b))
                    begin
                        remaining = (word > rwhp_pkg::FMT_BODY_BYTES) ?
                            word - rwhp_pkg::FMT_BODY_BYTES : '0;
                        phase = PH_FMT_BODY;
                    end
                PH_FMT_BODY:
                begin
                    word = {b, word[31:8]};
                    case (idx)
                        5'd1:  tag = word[31:16];
                        5'd3:  chans = word[31:16];
                        5'd7:  rate = word;
                        5'd11: brate = word;
                        5'd13: align = word[31:16];
                        5'd15: bits = word[31:16];
                        default: ;
                    endcase
                    idx = idx + 5'd1;
                    if (idx >= 5'd16)
                    begin
                        idx = '0;
                        phase = (remaining != 0) ? PH_FMT_EXTRA : PH_CHUNK_ID;
                    end
                end
                PH_FMT_EXTRA, PH_SKIP:
                begin
                    r.status = rwhp_pkg::ST_SKIPPED;
                    remaining = remaining - 32'd1;
                    if (remaining == 0)
                        phase = PH_CHUNK_ID;
                end
                PH_CHUNK_ID:
                    if (shift_in(b))
                    begin
                        chunk_id = word;
                        phase = PH_CHUNK_SIZE;
                    end
                PH_CHUNK_SIZE:
                    if (shift_in(b))
                    begin
                        remaining = word;
                        if (chunk_id == rwhp_pkg::ID_DATA)
                            phase = (word != 0) ? PH_DATA : PH_DONE;
                        else
                            phase = (word != 0) ? PH_SKIP : PH_CHUNK_ID;
                    end
                PH_DATA:
                begin
                    r.status = rwhp_pkg::ST_SAMPLE;
                    r.sample = b;
                    remaining = remaining - 32'd1;
                    r.left = remaining;
                    if (remaining == 0)
                    begin
                        r.last = 1'b1;
                        phase = PH_DONE;
                    end
                end
                default:
                begin
                    r.status = rwhp_pkg::ST_IGNORED;
                    phase = PH_DONE;
                end
            endcase
            r.tag = tag;
            r.chans = chans;
            r.rate = rate;
            r.brate = brate;
            r.align = align;
            r.bits = bits;
            pending_results.push_back(r);
            return r.status;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void diff(string fname, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            end
        endfunction

        function void check_result(wav_result_t got);
            wav_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %h",
                         $time, got.status);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            diff("status", 32'(want.status), 32'(got.status));
            diff("sample_byte", 32'(want.sample), 32'(got.sample));
            diff("last_sample", 32'(want.last), 32'(got.last));
            diff("format_tag", 32'(want.tag), 32'(got.tag));
            diff("channel_count", 32'(want.chans), 32'(got.chans));
            diff("sample_rate", want.rate, got.rate);
            diff("byte_rate", want.brate, got.brate);
            diff("block_align", 32'(want.align), 32'(got.align));
            diff("bits_per_sample", 32'(want.bits), 32'(got.bits));
            diff("data_bytes_left", want.left, got.left);
            if (want.status == rwhp_pkg::ST_SAMPLE)
                samples++;
            if (want.status == rwhp_pkg::ST_SKIPPED)
                skipped++;
            if (want.last)
                lasts++;
            if (want.status == rwhp_pkg::ST_BAD_RIFF || want.status == rwhp_pkg::ST_BAD_WAVE ||
                want.status == rwhp_pkg::ST_BAD_FMT)
                bad_ids++;
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] in_byte
    logic [0:0]   s_tuser;   // [0] start_of_file
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;   // [7:0] sample_byte, [23:8] format_tag,
                             // [39:24] channel_count, [71:40] sample_rate,
                             // [103:72] byte_rate, [119:104] block_align,
                             // [135:120] bits_per_sample, [167:136] data_bytes_left
    logic [2:0]   m_tuser;   // [2:0] status
    logic         m_tlast;

    wav_parse_tracker tracker = new();
    bit idling_on = 1'b1;
    int live_items = 0;
    int file_count = 0;

    riff_wave_header_parser dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Capture every result transaction
    always @(posedge clk)
    begin
        wav_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tuser;
            got.sample = m_tdata[7:0];
            got.last = m_tlast;
            got.tag = m_tdata[23:8];
            got.chans = m_tdata[39:24];
            got.rate = m_tdata[71:40];
            got.brate = m_tdata[103:72];
            got.align = m_tdata[119:104];
            got.bits = m_tdata[135:120];
            got.left = m_tdata[167:136];
            tracker.check_result(got);
        end
    end

    // Receiver back-pressure in bursts
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, logic sof);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= sof;
        do
            @(posedge clk);
        while (!s_tready);
        if (tracker.predict_byte(b, sof) != rwhp_pkg::ST_IGNORED)
            live_items++;
    endtask

    task automatic send_word(logic [31:0] w, logic sof);
        send_byte(w[7:0], sof);
        send_byte(w[15:8], 1'b0);
        send_byte(w[23:16], 1'b0);
        send_byte(w[31:24], 1'b0);
    endtask

    task automatic send_random(int n);
        repeat (n) send_byte(8'($urandom), 1'b0);
    endtask

    // Flip one bit so the identifier check fails on its fourth byte
    function automatic logic [31:0] spoil(logic [31:0] id);
        return id ^ (32'd1 << $urandom_range(0, 31));
    endfunction

    // One file, mostly well formed; truncated files are cut by the next start mark
    task automatic send_file();
        int kind;
        int sel;
        int fill;
        logic [31:0] fmt_size;
        logic [31:0] size;
        logic [31:0] cid;
        logic [7:0]  b;
        kind = $urandom_range(0, 19);
        file_count++;
        send_word(kind == 0 ? spoil(rwhp_pkg::ID_RIFF) : rwhp_pkg::ID_RIFF, 1'b1);
        if (kind == 0)
        begin
            send_random($urandom_range(0, 2));
            return;
        end
        send_word($urandom, 1'b0);
        send_word(kind == 1 ? spoil(rwhp_pkg::ID_WAVE) : rwhp_pkg::ID_WAVE, 1'b0);
        if (kind == 1)
        begin
            send_random($urandom_range(0, 2));
            return;
        end
        send_word(kind == 2 ? spoil(rwhp_pkg::ID_FMT) : rwhp_pkg::ID_FMT, 1'b0);
        if (kind == 2)
        begin
            send_random($urandom_range(0, 2));
            return;
        end
        sel = $urandom_range(0, 9);
        if (sel < 5)
            fmt_size = 32'd16;
        else if (sel < 7)
            fmt_size = $urandom_range(0, 15);
        else if (sel < 9)
            fmt_size = 32'd16 + $urandom_range(1, 6);
        else
            fmt_size = $urandom;
        send_word(fmt_size, 1'b0);
        fill = $urandom_range(0, 5);
        repeat (16)
        begin
            b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
            send_byte(b, 1'b0);
        end
        if (fmt_size > 32'd24)
        begin
            send_random($urandom_range(1, 6));
            return;
        end
        if (fmt_size > 32'd16)
            send_random(int'(fmt_size - 32'd16));
        repeat ($urandom_range(0, 2))
        begin
            cid = $urandom;
            if (cid == rwhp_pkg::ID_DATA)
                cid = spoil(cid);
            sel = $urandom_range(0, 9);
            size = (sel == 0) ? 32'd0 : (sel == 9) ? ($urandom | 32'h100) :
                   32'($urandom_range(1, 7));
            send_word(cid, 1'b0);
            send_word(size, 1'b0);
            if (size > 32'd7)
            begin
                send_random($urandom_range(1, 6));
                return;
            end
            send_random(int'(size));
        end
        send_word(rwhp_pkg::ID_DATA, 1'b0);
        sel = $urandom_range(0, 9);
        if (sel == 0)
            size = 32'd0;
        else if (sel == 1)
            size = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
        else
            size = $urandom_range(1, 12);
        send_word(size, 1'b0);
        if (size > 32'd12)
        begin
            send_random($urandom_range(1, 6));
            return;
        end
        send_random(int'(size));
        send_random($urandom_range(0, 3));
    endtask

    initial
    begin
        int guard;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No start mark after reset, bad RIFF, then one ignored byte
        send_word({8'h58, rwhp_pkg::ID_RIFF[23:0]}, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Bad WAVE behind an all-ones RIFF size, then an all-zero ignored byte
        send_word(rwhp_pkg::ID_RIFF, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word({rwhp_pkg::ID_WAVE[31:8], 8'h00}, 1'b0);
        send_byte(8'h00, 1'b0);

        // Hold the sender until the block has drained
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);

        live_items = 0;
        while (live_items < 400)
        begin
            if (live_items > 330)
                idling_on = 1'b0;
            send_file();
        end
        s_tvalid <= 1'b0;

        guard = 0;
        while (tracker.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (tracker.pending() != 0)
        begin
            tracker.errors++;
            $display("%0t: %0d expected results never arrived", $time, tracker.pending());
        end
        $display("Covered %0d files, %0d results: %0d sample bytes, %0d last marks,",
                 file_count, tracker.checked, tracker.samples, tracker.lasts);
        $display("%0d skipped bytes and %0d identifier errors; %0d mismatches.",
                 tracker.skipped, tracker.bad_ids, tracker.errors);
        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
